@@ rtl/avp_pkg.sv @@
// Shared types, constants and small arithmetic helpers for the average pooling block.
// No dependencies; imported by avp_front, avp_back and the top level.
`default_nettype none

package avp_pkg;

    // Upper limits that set the widths of the fields carried between modules
    localparam int POOL_LIM = 8;
    localparam int ADDR_W   = 12;
    localparam int SUM_W    = 22;
    localparam int RECIP_K  = 28;
    localparam int RECIP_W  = 29;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 9;

    localparam logic [CFG_IDX_W-1:0] REG_IN_COLS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IN_ROWS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POOL_SIZE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PLANES    = 3'd4;

    // Configuration after clamping
    typedef struct packed {
        logic [8:0] cols;
        logic [8:0] rows;
        logic [8:0] planes;
        logic [3:0] pool;
        logic [2:0] stride;
    } t_cfg;

    // One classified sample on its way from the front to the back
    typedef struct packed {
        logic signed [15:0]  sample;
        logic [2:0]          wr_bank;
        logic [ADDR_W-1:0]   wr_addr;
        logic                emit;
        logic [ADDR_W-1:0]   c0;
        logic [POOL_LIM-1:0] mask;
        logic [3:0]          pool;
        logic [7:0]          orow;
        logic [7:0]          ocol;
        logic [7:0]          plane;
        logic                last;
    } t_job;

    typedef struct packed {
        logic signed [15:0] average_value;
        logic [7:0]         out_row;
        logic [7:0]         out_col;
        logic [7:0]         plane_index;
        logic               plane_done;
    } t_res;

    // Quotient of an 8-bit value by a stride of 1..7: reciprocal multiply, exact for a < 256
    function automatic logic [7:0] div_small(input logic [7:0] a, input logic [2:0] s);
        logic [11:0] m;
        logic [19:0] prod;
        unique case (s)
            3'd2:    m = 12'd1024;
            3'd3:    m = 12'd683;
            3'd4:    m = 12'd512;
            3'd5:    m = 12'd410;
            3'd6:    m = 12'd342;
            3'd7:    m = 12'd293;
            default: m = 12'd2048;
        endcase
        prod = 20'(a) * 20'(m);
        return prod[18:11];
    endfunction

    // ceil(2^RECIP_K / (p*p)) for window sides 1..8
    function automatic logic [RECIP_W-1:0] recip_sq(input logic [3:0] p);
        logic [RECIP_W-1:0] m;
        unique case (p)
            4'd2:    m = 29'd67108864;
            4'd3:    m = 29'd29826162;
            4'd4:    m = 29'd16777216;
            4'd5:    m = 29'd10737419;
            4'd6:    m = 29'd7456541;
            4'd7:    m = 29'd5478275;
            4'd8:    m = 29'd4194304;
            default: m = 29'd268435456;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

@@ rtl/avp_fifo.sv @@
// Small synchronous queue used between front and back and on the result side.
// No dependencies.
`default_nettype none

module avp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_data [DEPTH];
    logic [PW-1:0]    r_wptr, r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_data[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_data[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/avp_front.sv @@
// Front end: accepts samples, tracks column/row/plane and classifies each sample.
// Depends on avp_pkg.
`default_nettype none

module avp_front import avp_pkg::*; #(
    parameter int MAX_COLS = 256,
    parameter int MAX_POOL = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cfg               i_cfg,
    input  wire logic               i_push,
    input  wire logic signed [15:0] i_sample,
    output logic                    o_full,
    output logic                    o_job_vld,
    output t_job                    o_job,
    input  wire logic               i_job_full
);

    localparam int MC_RECIP = ((1 << 20) + MAX_COLS - 1) / MAX_COLS;
    localparam int MP_RECIP = ((1 << 11) + MAX_POOL - 1) / MAX_POOL;

    logic [7:0]         r_col, r_row, r_plane;
    logic               r_s1_vld;
    logic signed [15:0] r_s1_sample;
    logic [7:0]         r_s1_r, r_s1_c, r_s1_plane;

    logic accept;

    function automatic logic [2:0] mod_pool(input logic [7:0] a);
        logic [19:0] prod;
        logic [11:0] rem;
        prod = 20'(a) * 20'(MP_RECIP);
        rem  = 12'(a) - 12'(prod[18:11]) * 12'(MAX_POOL);
        return rem[2:0];
    endfunction

    function automatic logic [ADDR_W-1:0] mod_cols(input logic [7:0] a);
        logic [27:0] prod;
        logic [19:0] rem;
        prod = 28'(a) * 28'(MC_RECIP);
        rem  = 20'(a) - 20'(prod[27:20]) * 20'(MAX_COLS);
        return rem[ADDR_W-1:0];
    endfunction

    assign o_full    = r_s1_vld && i_job_full;
    assign accept    = i_push && !o_full;
    assign o_job_vld = r_s1_vld;

    // Position counters and the stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_plane  <= '0;
            r_s1_vld <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_vld    <= 1'b1;
                r_s1_sample <= i_sample;
                r_s1_r      <= r_row;
                r_s1_c      <= r_col;
                r_s1_plane  <= r_plane;
                if (({1'b0, r_col} + 9'd1) >= i_cfg.cols) begin
                    r_col <= '0;
                    if (({1'b0, r_row} + 9'd1) >= i_cfg.rows) begin
                        r_row   <= '0;
                        r_plane <= (({1'b0, r_plane} + 9'd1) >= i_cfg.planes) ?
                                   '0 : r_plane + 8'd1;
                    end else begin
                        r_row <= r_row + 8'd1;
                    end
                end else begin
                    r_col <= r_col + 8'd1;
                end
            end else if (!i_job_full) begin
                r_s1_vld <= 1'b0;
            end
        end
    end

    // Classification of the staged sample
    always_comb begin
        logic [8:0]  p9, r1, c1;
        logic [7:0]  r0, c0, qr, qc, qlr, qlc;
        logic        cand, zr, zc, fits_r, fits_c;
        logic [2:0]  b0;
        logic [3:0]  bank_off;
        p9     = 9'(i_cfg.pool);
        r1     = {1'b0, r_s1_r} + 9'd1;
        c1     = {1'b0, r_s1_c} + 9'd1;
        cand   = (r1 >= p9) && (c1 >= p9);
        r0     = 8'(r1 - p9);
        c0     = 8'(c1 - p9);
        qr     = div_small(r0, i_cfg.stride);
        qc     = div_small(c0, i_cfg.stride);
        zr     = (11'(r0) == 11'(qr) * 11'(i_cfg.stride));
        zc     = (11'(c0) == 11'(qc) * 11'(i_cfg.stride));
        fits_r = ({1'b0, r0} + p9) <= i_cfg.rows;
        fits_c = ({1'b0, c0} + p9) <= i_cfg.cols;
        qlr    = div_small(8'(i_cfg.rows - p9), i_cfg.stride);
        qlc    = div_small(8'(i_cfg.cols - p9), i_cfg.stride);
        b0     = mod_pool(r0);

        o_job.sample  = r_s1_sample;
        o_job.wr_bank = mod_pool(r_s1_r);
        o_job.wr_addr = mod_cols(r_s1_c);
        o_job.emit    = cand && zr && zc && fits_r && fits_c;
        o_job.c0      = ADDR_W'(c0);
        o_job.pool    = i_cfg.pool;
        o_job.orow    = qr;
        o_job.ocol    = qc;
        o_job.plane   = r_s1_plane;
        o_job.last    = (qr == qlr) && (qc == qlc);
        // a bank takes part when its distance from the window's top row is below the side
        for (int k = 0; k < POOL_LIM; k++) begin
            if (k < MAX_POOL) begin
                bank_off = (4'(k) >= {1'b0, b0}) ? 4'(k) - {1'b0, b0}
                                                 : 4'(k + MAX_POOL) - {1'b0, b0};
                o_job.mask[k] = (bank_off < i_cfg.pool);
            end else begin
                o_job.mask[k] = 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/avp_back.sv @@
// Back end: banked line store, column-serial window sum and reciprocal divide.
// Depends on avp_pkg.
`default_nettype none

module avp_back import avp_pkg::*; #(
    parameter int MAX_COLS = 256,
    parameter int MAX_POOL = 4
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_job_vld,
    input  wire t_job i_job,
    output logic      o_job_pop,
    output logic      o_res_push,
    output t_res      o_res,
    input  wire logic i_res_full
);

    localparam int CW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int BANK_W = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;
    localparam int PROD_W = SUM_W + RECIP_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_DRAIN,
        S_DIV1,
        S_DIV2,
        S_OUT
    } t_state;

    logic [15:0] r_mem [MAX_POOL][MAX_COLS];
    logic [15:0] r_rdata [MAX_POOL];

    t_state              r_state;
    logic [CW-1:0]       r_raddr;
    logic [3:0]          r_left;
    logic [POOL_LIM-1:0] r_mask;
    logic [3:0]          r_pool;
    logic [7:0]          r_orow, r_ocol, r_plane;
    logic                r_last;
    logic                r_rd_vld, r_cs_vld;
    logic signed [SUM_W-1:0] r_colsum, r_acc;
    logic                r_neg;
    logic [SUM_W-1:0]    r_abs;
    logic [RECIP_W-1:0]  r_m;
    logic [PROD_W-1:0]   r_prod;

    logic signed [SUM_W-1:0] colsum;
    logic [16:0]             quot;

    assign o_job_pop  = (r_state == S_IDLE) && i_job_vld;
    assign o_res_push = (r_state == S_OUT) && !i_res_full;

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_mem[i_job.wr_bank[BANK_W-1:0]][i_job.wr_addr[CW-1:0]] <= i_job.sample;
        end
        for (int k = 0; k < MAX_POOL; k++) begin
            r_rdata[k] <= r_mem[k][r_raddr];
        end
    end

    always_comb begin
        colsum = '0;
        for (int k = 0; k < MAX_POOL; k++) begin
            if (r_mask[k]) begin
                colsum = colsum + SUM_W'($signed(r_rdata[k]));
            end
        end
    end

    assign quot = r_prod[RECIP_K +: 17];

    always_comb begin
        o_res.average_value = r_neg ? 16'(17'd0 - quot) : 16'(quot);
        o_res.out_row       = r_orow;
        o_res.out_col       = r_ocol;
        o_res.plane_index   = r_plane;
        o_res.plane_done    = r_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rd_vld <= 1'b0;
            r_cs_vld <= 1'b0;
        end else begin
            r_rd_vld <= (r_state == S_READ);
            r_cs_vld <= r_rd_vld;
            if (r_rd_vld) begin
                r_colsum <= colsum;
            end
            if (r_cs_vld) begin
                r_acc <= r_acc + r_colsum;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_vld && i_job.emit) begin
                        r_raddr <= i_job.c0[CW-1:0];
                        r_left  <= i_job.pool;
                        r_mask  <= i_job.mask;
                        r_pool  <= i_job.pool;
                        r_orow  <= i_job.orow;
                        r_ocol  <= i_job.ocol;
                        r_plane <= i_job.plane;
                        r_last  <= i_job.last;
                        r_acc   <= '0;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    // one column of all banks per cycle
                    r_raddr <= r_raddr + 1'b1;
                    r_left  <= r_left - 4'd1;
                    if (r_left == 4'd1) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!r_rd_vld && !r_cs_vld) begin
                        r_state <= S_DIV1;
                    end
                end
                S_DIV1: begin
                    r_neg   <= r_acc[SUM_W-1];
                    r_abs   <= r_acc[SUM_W-1] ? SUM_W'(-r_acc) : SUM_W'(r_acc);
                    r_m     <= recip_sq(r_pool);
                    r_state <= S_DIV2;
                end
                S_DIV2: begin
                    r_prod  <= PROD_W'(r_abs) * PROD_W'(r_m);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!i_res_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/average_pool_2d_top.sv @@
// Streaming 2-D average pooling, top level. Uses avp_pkg, avp_front, avp_fifo, avp_back.
// A sample reaches the back via the front stage register and the job queue. Samples that
// close no window pass at one per cycle while the back is idle; a window holds the back
// through its column-serial line store read, drain, divide steps and result push.
// Reset is synchronous, active low: counters, queues, states and config registers return to
// defaults; data registers and the line store are not cleared.
`default_nettype none

module average_pool_2d_top import avp_pkg::*; #(
    parameter int MAX_COLS = 256,
    parameter int MAX_POOL = 4
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data,
    input  wire logic                 push,
    output logic                      full,
    input  wire logic signed [15:0]   i_sample_value,
    output logic                      empty,
    input  wire logic                 pop,
    output logic signed [15:0]        o_average_value,
    output logic [7:0]                o_out_row,
    output logic [7:0]                o_out_col,
    output logic [7:0]                o_plane_index,
    output logic                      o_plane_done
);

    localparam int COL_LIM = (MAX_COLS < 256) ? MAX_COLS : 256;

    logic [8:0] r_in_cols, r_in_rows, r_planes;
    logic [2:0] r_pool_size, r_stride;

    t_cfg cfg;
    t_job front_job, back_job;
    t_res back_res, out_res;
    logic front_vld, job_full, job_empty, job_pop;
    logic res_push, res_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_cols   <= 9'd8;
            r_in_rows   <= 9'd8;
            r_pool_size <= 3'd2;
            r_stride    <= 3'd2;
            r_planes    <= 9'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_IN_COLS:   r_in_cols   <= i_cfg_data;
                REG_IN_ROWS:   r_in_rows   <= i_cfg_data;
                REG_POOL_SIZE: r_pool_size <= i_cfg_data[2:0];
                REG_STRIDE:    r_stride    <= i_cfg_data[2:0];
                REG_PLANES:    r_planes    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamp registers to their legal ranges
    always_comb begin
        cfg.cols   = (r_in_cols == '0) ? 9'd1 :
                     (r_in_cols > 9'(COL_LIM)) ? 9'(COL_LIM) : r_in_cols;
        cfg.rows   = (r_in_rows == '0) ? 9'd1 : (r_in_rows > 9'd256) ? 9'd256 : r_in_rows;
        cfg.planes = (r_planes == '0) ? 9'd1 : (r_planes > 9'd256) ? 9'd256 : r_planes;
        cfg.pool   = (r_pool_size == '0) ? 4'd1 :
                     (4'(r_pool_size) > 4'(MAX_POOL)) ? 4'(MAX_POOL) : 4'(r_pool_size);
        cfg.stride = (r_stride == '0) ? 3'd1 : r_stride;
    end

    avp_front #(.MAX_COLS(MAX_COLS), .MAX_POOL(MAX_POOL)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_push     (push),
        .i_sample   (i_sample_value),
        .o_full     (full),
        .o_job_vld  (front_vld),
        .o_job      (front_job),
        .i_job_full (job_full)
    );

    avp_fifo #(.WIDTH($bits(t_job)), .DEPTH(2)) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_vld),
        .i_data  (front_job),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_data  (back_job),
        .o_empty (job_empty)
    );

    avp_back #(.MAX_COLS(MAX_COLS), .MAX_POOL(MAX_POOL)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job_vld  (!job_empty),
        .i_job      (back_job),
        .o_job_pop  (job_pop),
        .o_res_push (res_push),
        .o_res      (back_res),
        .i_res_full (res_full)
    );

    avp_fifo #(.WIDTH($bits(t_res)), .DEPTH(2)) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (back_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (out_res),
        .o_empty (empty)
    );

    assign o_average_value = out_res.average_value;
    assign o_out_row       = out_res.out_row;
    assign o_out_col       = out_res.out_col;
    assign o_plane_index   = out_res.plane_index;
    assign o_plane_done    = out_res.plane_done;

    a_reset_clean: assert property (@(posedge i_clk) !i_rst_n |=> !full && empty)
        else $error("queues not cleared by reset");

    a_res_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !res_full)
        else $error("result pushed into full queue");

    a_job_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_pop |-> !job_empty)
        else $error("back took an item from an empty queue");

    a_full_needs_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> front_vld && job_full)
        else $error("front stalled without a blocked item");

endmodule

`default_nettype wire
